@@ design/assert_macros.svh @@
// Assertion macros shared by the worker health tracker RTL.
// Included by bare file name from the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/whtr_pkg.sv @@
// Package for the worker health tracker: codes, payload structs and defaults.
// No dependencies; used by whtr_update, the top level and the testbench.
`default_nettype none

package whtr_pkg;

    localparam int WORKERS_DEF     = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FUNC_W          = 3;
    localparam int WIDX_W          = 4;
    localparam int LAT_W           = 20;
    localparam int THR_W           = 16;
    localparam int CNT_OUT_W       = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [THR_W-1:0] DEGRADE_RST = 16'd2;
    localparam logic [THR_W-1:0] FAIL_RST    = 16'd5;
    localparam logic [THR_W-1:0] RECOVER_RST = 16'd3;

    typedef enum logic [FUNC_W-1:0] {
        FN_SUCCESS   = 3'd0,
        FN_FAILURE   = 3'd1,
        FN_SET_DRAIN = 3'd2,
        FN_CLR_DRAIN = 3'd3,
        FN_INSTALL   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        HL_HEALTHY  = 2'd0,
        HL_DEGRADED = 2'd1,
        HL_DRAINING = 2'd2,
        HL_FAILED   = 2'd3
    } t_health;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEGRADE = 2'd0,
        CFG_FAIL    = 2'd1,
        CFG_RECOVER = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WIDX_W-1:0] worker;
        logic [LAT_W-1:0]  lat_sample;
        logic [1:0]        install_health;
    } t_evt;

    typedef struct packed {
        logic                 accepted;
        logic [1:0]           health;
        logic [LAT_W-1:0]     latency_estimate;
        logic [CNT_OUT_W-1:0] failure_count;
        logic [CNT_OUT_W-1:0] success_count;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [THR_W-1:0]     value;
    } t_cfg;

    typedef struct packed {
        logic [THR_W-1:0] degrade;
        logic [THR_W-1:0] fail;
        logic [THR_W-1:0] recover;
    } t_thresh;

endpackage

`default_nettype wire

@@ design/whtr_chan_if.sv @@
// Valid/ready channel interface carrying one payload type per transaction.
// Depends on nothing; the payload type comes in as a parameter.
`default_nettype none

interface whtr_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/whtr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module whtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

@@ design/whtr_update.sv @@
// Next-state logic for one worker entry under one event.
// Depends on whtr_pkg for codes, the event struct and the thresholds.
`default_nettype none

module whtr_update #(
    parameter int CW = whtr_pkg::COUNT_WIDTH_DEF
) (
    input  wire whtr_pkg::t_evt                i_evt,
    input  wire whtr_pkg::t_thresh             i_thr,
    input  wire logic                          i_valid,
    input  wire logic [1:0]                    i_health,
    input  wire logic [whtr_pkg::LAT_W-1:0]    i_lat,
    input  wire logic [CW-1:0]                 i_fcnt,
    input  wire logic [CW-1:0]                 i_scnt,
    output logic                               o_accepted,
    output logic                               o_valid,
    output logic [1:0]                         o_health,
    output logic [whtr_pkg::LAT_W-1:0]         o_lat,
    output logic [CW-1:0]                      o_fcnt,
    output logic [CW-1:0]                      o_scnt
);
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};
    localparam int LW = whtr_pkg::LAT_W;

    logic            usable;
    logic            live;
    logic [CW-1:0]   f_inc;
    logic [CW-1:0]   s_inc;
    logic [LW+2:0]   lat_sum;

    // Counts saturate at all ones.
    assign f_inc = (i_fcnt == CMAX) ? i_fcnt : i_fcnt + 1'b1;
    assign s_inc = (i_scnt == CMAX) ? i_scnt : i_scnt + 1'b1;

    // Three times the old estimate plus the new sample, then divided by four.
    assign lat_sum = {2'b00, i_lat, 1'b0} + {3'b000, i_lat} + {3'b000, i_evt.lat_sample};

    assign live   = i_valid && (i_health != whtr_pkg::HL_FAILED);
    assign usable = live && (i_health != whtr_pkg::HL_DRAINING);

    always_comb begin
        o_accepted = 1'b0;
        o_valid    = i_valid;
        o_health   = i_health;
        o_lat      = i_lat;
        o_fcnt     = i_fcnt;
        o_scnt     = i_scnt;
        unique case (whtr_pkg::t_func'(i_evt.func))
            whtr_pkg::FN_SUCCESS: begin
                if (usable) begin
                    o_accepted = 1'b1;
                    o_lat      = lat_sum[LW+1:2];
                    o_fcnt     = '0;
                    o_scnt     = s_inc;
                    if (i_health == whtr_pkg::HL_DEGRADED &&
                        32'(s_inc) >= 32'(i_thr.recover)) begin
                        o_health = whtr_pkg::HL_HEALTHY;
                        o_scnt   = '0;
                    end
                end
            end
            whtr_pkg::FN_FAILURE: begin
                if (usable) begin
                    o_accepted = 1'b1;
                    o_scnt     = '0;
                    o_fcnt     = f_inc;
                    if (32'(f_inc) >= 32'(i_thr.fail)) begin
                        o_health = whtr_pkg::HL_FAILED;
                    end else if (32'(f_inc) >= 32'(i_thr.degrade)) begin
                        o_health = whtr_pkg::HL_DEGRADED;
                    end
                end
            end
            whtr_pkg::FN_SET_DRAIN: begin
                if (live) begin
                    o_accepted = 1'b1;
                    o_health   = whtr_pkg::HL_DRAINING;
                end
            end
            whtr_pkg::FN_CLR_DRAIN: begin
                if (live) begin
                    o_accepted = 1'b1;
                    o_health   = whtr_pkg::HL_HEALTHY;
                    o_fcnt     = '0;
                    o_scnt     = '0;
                end
            end
            whtr_pkg::FN_INSTALL: begin
                o_accepted = 1'b1;
                o_valid    = 1'b1;
                o_health   = i_evt.install_health;
                o_lat      = i_evt.lat_sample;
                o_fcnt     = '0;
                o_scnt     = '0;
            end
            default: begin
                // Unused function codes are refused and change nothing.
            end
        endcase
    end
endmodule

`default_nettype wire

@@ design/worker_health_tracker.sv @@
// Worker health tracker top level: entry RAM, read/modify/write pipeline, config.
// Depends on whtr_pkg, whtr_chan_if, whtr_ram, whtr_update and assert_macros.svh.
//
//   Port     Dir   Payload          Purpose
//   i_evt    in    whtr_pkg::t_evt  one event transaction naming one worker
//   o_res    out   whtr_pkg::t_res  one result transaction per event
//   i_cfg    in    whtr_pkg::t_cfg  threshold register writes (always ready)
//
// Sustained rate is one event per cycle while the output is not stalled. The RAM
// read is registered at the edge that accepts an event; the update and write-back
// follow in the read stage, which moves the result into the output register.
// After reset the entry RAM is swept to zero, one entry per cycle; events are
// held off during the sweep, configuration writes are taken.
// A stalled output holds the pipeline stage behind it, which then holds the input.
`default_nettype none

`include "assert_macros.svh"

module worker_health_tracker #(
    parameter int WORKERS     = whtr_pkg::WORKERS_DEF,
    parameter int COUNT_WIDTH = whtr_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    whtr_chan_if.sink   i_evt,
    whtr_chan_if.sink   i_cfg,
    whtr_chan_if.source o_res
);
    localparam int AW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int LW = whtr_pkg::LAT_W;
    localparam int CW = COUNT_WIDTH;
    localparam int OW = whtr_pkg::CNT_OUT_W;
    // Entry word: valid, health, latency estimate, failure count, success count.
    localparam int EW = 3 + LW + 2 * CW;

    // Threshold registers.
    whtr_pkg::t_thresh r_thr;

    // Clearing sweep after reset.
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // Read stage: the event whose entry is being read from the RAM.
    logic           r_s1_vld;
    whtr_pkg::t_evt r_s1_evt;
    logic [AW-1:0]  r_s1_addr;
    logic           r_s1_inrange;

    // Copy of the most recent entry write, for a read that raced it.
    logic           r_fwd_vld;
    logic [AW-1:0]  r_fwd_addr;
    logic [EW-1:0]  r_fwd_data;

    // Output register.
    logic           r_out_vld;
    whtr_pkg::t_res r_out;

    logic           evt_acc;
    logic           s1_adv;
    logic [AW-1:0]  evt_addr;
    logic           evt_inrange;
    logic [EW-1:0]  ram_rdata;
    logic [EW-1:0]  cur_entry;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [EW-1:0]  ram_wdata;
    logic [EW-1:0]  new_entry;

    logic           upd_acc;
    logic           upd_valid;
    logic [1:0]     upd_health;
    logic [LW-1:0]  upd_lat;
    logic [CW-1:0]  upd_fcnt;
    logic [CW-1:0]  upd_scnt;

    whtr_pkg::t_res n_out;

    // Handshakes. The read stage moves on whenever the output register is free
    // or being emptied; a new event enters whenever the read stage moves on.
    assign s1_adv      = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_evt.ready = !r_clr_busy && (!r_s1_vld || s1_adv);
    assign evt_acc     = i_evt.valid && i_evt.ready;
    assign i_cfg.ready = 1'b1;

    assign evt_addr    = AW'(i_evt.data.worker);
    assign evt_inrange = 32'(i_evt.data.worker) < WORKERS;

    // An event read the RAM in the same cycle that the previous event wrote the
    // same entry, so the RAM returned the old word; take the forwarded copy.
    assign cur_entry = (r_fwd_vld && r_fwd_addr == r_s1_addr) ? r_fwd_data : ram_rdata;

    whtr_update #(
        .CW (CW)
    ) u_update (
        .i_evt      (r_s1_evt),
        .i_thr      (r_thr),
        .i_valid    (cur_entry[EW-1]),
        .i_health   (cur_entry[EW-2 -: 2]),
        .i_lat      (cur_entry[2*CW +: LW]),
        .i_fcnt     (cur_entry[CW +: CW]),
        .i_scnt     (cur_entry[0 +: CW]),
        .o_accepted (upd_acc),
        .o_valid    (upd_valid),
        .o_health   (upd_health),
        .o_lat      (upd_lat),
        .o_fcnt     (upd_fcnt),
        .o_scnt     (upd_scnt)
    );

    assign new_entry = {upd_valid, upd_health, upd_lat, upd_fcnt, upd_scnt};

    // The sweep owns the write port until it finishes; afterwards only applied
    // events write back.
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_adv && r_s1_inrange && upd_acc;
            ram_waddr = r_s1_addr;
            ram_wdata = new_entry;
        end
    end

    whtr_ram #(
        .WIDTH (EW),
        .DEPTH (WORKERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (evt_acc),
        .i_raddr (evt_addr),
        .o_rdata (ram_rdata)
    );

    // A worker index beyond the table reports all zeros and is refused.
    always_comb begin
        if (r_s1_inrange) begin
            n_out.accepted         = upd_acc;
            n_out.health           = upd_health;
            n_out.latency_estimate = upd_lat;
            n_out.failure_count    = OW'(32'(upd_fcnt));
            n_out.success_count    = OW'(32'(upd_scnt));
        end else begin
            n_out = '0;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.degrade <= whtr_pkg::DEGRADE_RST;
            r_thr.fail    <= whtr_pkg::FAIL_RST;
            r_thr.recover <= whtr_pkg::RECOVER_RST;
            r_clr_busy    <= 1'b1;
            r_clr_addr    <= '0;
            r_s1_vld      <= 1'b0;
            r_fwd_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (whtr_pkg::t_cfg_idx'(i_cfg.data.index))
                    whtr_pkg::CFG_DEGRADE: r_thr.degrade <= i_cfg.data.value;
                    whtr_pkg::CFG_FAIL:    r_thr.fail    <= i_cfg.data.value;
                    whtr_pkg::CFG_RECOVER: r_thr.recover <= i_cfg.data.value;
                    default: begin
                        // Writes beyond the register list are dropped.
                    end
                endcase
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(WORKERS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (evt_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (!r_clr_busy && ram_we) begin
                r_fwd_vld <= 1'b1;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (evt_acc) begin
            r_s1_evt     <= i_evt.data;
            r_s1_addr    <= evt_addr;
            r_s1_inrange <= evt_inrange;
        end
        if (!r_clr_busy && ram_we) begin
            r_fwd_addr <= ram_waddr;
            r_fwd_data <= ram_wdata;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    // An applied event leaves its entry in the forwarding copy for the next read.
    `WHT_ASSERT_NEXT(a_fwd_after_write, i_clk, i_rst_n, s1_adv && r_s1_inrange && upd_acc, r_fwd_vld && r_fwd_addr == $past(r_s1_addr), "write-back not captured for forwarding")
    // A read stage blocked by the output keeps its event.
    `WHT_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_vld && !s1_adv, r_s1_vld && $stable(r_s1_addr), "read stage lost its event while stalled")
    // No event is in flight while the sweep owns the RAM.
    `WHT_ASSERT_IMPL(a_clr_quiet, i_clk, i_rst_n, r_clr_busy, !r_s1_vld && !r_out_vld, "event in flight during clearing sweep")
    // Every event leaving the read stage lands in the output register.
    `WHT_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, s1_adv, r_out_vld, "result dropped after update")
endmodule

`default_nettype wire

@@ tb/worker_health_tracker_test.sv @@
// Self-checking testbench for worker_health_tracker: drives events and threshold writes
// and checks every result against a predictor of the worker table held in a scoreboard.
// Depends on whtr_pkg, whtr_chan_if and the worker_health_tracker RTL.
`default_nettype none

module worker_health_tracker_test;
    import whtr_pkg::*;

    // Function codes above install are not decoded by the block and must be refused.
    localparam logic [FUNC_W-1:0] FN_RSVD_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD_HI = 3'd7;

    localparam logic [LAT_W-1:0]     LAT_MAX   = '1;
    localparam logic [CNT_OUT_W-1:0] COUNT_TOP = '1;
    localparam logic [THR_W-1:0]     THR_TOP   = '1;

    // Cycles without any transaction before the run is declared hung. The slowest
    // legitimate gap is the long output hold plus the pipeline delay.
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 64;
    localparam int CHUNKS       = 12;
    localparam int CHUNK_EVENTS = 73;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_RECOVER = 20;

    // Scoreboard: a private copy of the worker table and thresholds, updated for
    // every accepted event, plus the queue of results that the block owes us.
    class health_scoreboard;
        bit                   entry_on[WORKERS_DEF];
        t_health              health_tbl[WORKERS_DEF];
        logic [LAT_W-1:0]     latency_tbl[WORKERS_DEF];
        logic [CNT_OUT_W-1:0] fail_tbl[WORKERS_DEF];
        logic [CNT_OUT_W-1:0] success_tbl[WORKERS_DEF];
        logic [THR_W-1:0]     degrade_thr;
        logic [THR_W-1:0]     fail_thr;
        logic [THR_W-1:0]     recover_thr;
        t_res                 owed_q[$];
        int                   mismatches;
        int                   results_seen;
        int                   applied;
        int                   refused;

        function new();
            foreach (entry_on[i]) begin
                entry_on[i]    = 1'b0;
                health_tbl[i]  = HL_HEALTHY;
                latency_tbl[i] = '0;
                fail_tbl[i]    = '0;
                success_tbl[i] = '0;
            end
            degrade_thr  = DEGRADE_RST;
            fail_thr     = FAIL_RST;
            recover_thr  = RECOVER_RST;
            mismatches   = 0;
            results_seen = 0;
            applied      = 0;
            refused      = 0;
        endfunction

        function void set_threshold(t_cfg_idx idx, logic [THR_W-1:0] value);
            case (idx)
                CFG_DEGRADE: degrade_thr = value;
                CFG_FAIL:    fail_thr    = value;
                CFG_RECOVER: recover_thr = value;
                default: ;
            endcase
        endfunction

        function logic [CNT_OUT_W-1:0] bump(logic [CNT_OUT_W-1:0] v);
            return (v == COUNT_TOP) ? v : v + 1'b1;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Applies one accepted event to the table and queues the result it causes.
        function void note_event(t_evt evt);
            int              w;
            t_health         h;
            bit              usable;
            bit              ok;
            logic [LAT_W+1:0] blend;
            t_res            r;
            w      = evt.worker;
            h      = health_tbl[w];
            usable = entry_on[w] && h != HL_FAILED && h != HL_DRAINING;
            ok     = 1'b0;
            case (evt.func)
                FN_SUCCESS: if (usable) begin
                    blend = {2'b00, latency_tbl[w]} * 2'd3 + {2'b00, evt.lat_sample};
                    latency_tbl[w] = blend[LAT_W+1:2];
                    fail_tbl[w]    = '0;
                    success_tbl[w] = bump(success_tbl[w]);
                    if (h == HL_DEGRADED && success_tbl[w] >= recover_thr) begin
                        health_tbl[w]  = HL_HEALTHY;
                        success_tbl[w] = '0;
                    end
                    ok = 1'b1;
                end
                FN_FAILURE: if (usable) begin
                    success_tbl[w] = '0;
                    fail_tbl[w]    = bump(fail_tbl[w]);
                    // The failed test is made first, so it wins when thresholds cross.
                    if (fail_tbl[w] >= fail_thr)
                        health_tbl[w] = HL_FAILED;
                    else if (fail_tbl[w] >= degrade_thr)
                        health_tbl[w] = HL_DEGRADED;
                    ok = 1'b1;
                end
                FN_SET_DRAIN: if (entry_on[w] && h != HL_FAILED) begin
                    health_tbl[w] = HL_DRAINING;
                    ok = 1'b1;
                end
                FN_CLR_DRAIN: if (entry_on[w] && h != HL_FAILED) begin
                    health_tbl[w]  = HL_HEALTHY;
                    fail_tbl[w]    = '0;
                    success_tbl[w] = '0;
                    ok = 1'b1;
                end
                FN_INSTALL: begin
                    entry_on[w]    = 1'b1;
                    health_tbl[w]  = t_health'(evt.install_health);
                    latency_tbl[w] = evt.lat_sample;
                    fail_tbl[w]    = '0;
                    success_tbl[w] = '0;
                    ok = 1'b1;
                end
                default: ;
            endcase
            if (ok) applied++;
            else refused++;
            r.accepted         = ok;
            r.health           = health_tbl[w];
            r.latency_estimate = latency_tbl[w];
            r.failure_count    = fail_tbl[w];
            r.success_count    = success_tbl[w];
            owed_q.insert(owed_q.size(), r);
        endfunction

        // Compares one result transaction with the oldest one still owed.
        function void check_result(t_res got);
            t_res want;
            results_seen++;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Result %0d arrived with nothing outstanding: acc=%0b h=%0d",
                             results_seen, got.accepted, got.health);
                return;
            end
            want = owed_q.pop_front();
            if (got.accepted !== want.accepted || got.health !== want.health ||
                got.latency_estimate !== want.latency_estimate ||
                got.failure_count !== want.failure_count ||
                got.success_count !== want.success_count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Result %0d mismatch: expected acc=%0b h=%0d lat=%0h fc=%0d sc=%0d",
                             results_seen, want.accepted, want.health,
                             want.latency_estimate, want.failure_count, want.success_count);
                    $display("    actual            acc=%0b h=%0d lat=%0h fc=%0d sc=%0d",
                             got.accepted, got.health, got.latency_estimate,
                             got.failure_count, got.success_count);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    whtr_chan_if #(.T(t_evt)) evt_if ();
    whtr_chan_if #(.T(t_cfg)) cfg_if ();
    whtr_chan_if #(.T(t_res)) res_if ();

    worker_health_tracker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    health_scoreboard board = new();

    // Idling controls shared between the stimulus and the result receiver.
    bit tx_idle;
    bit rx_idle;
    int hold_requests;
    int cfg_writes;
    int stall_cycles;

    // Workers that the random stimulus keeps returning to, so that failure and
    // success streaks build up long enough to cross the thresholds.
    logic [WIDX_W-1:0] hot_a;
    logic [WIDX_W-1:0] hot_b;
    bit                fail_heavy;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: any transaction on any channel resets the count of quiet cycles.
    always @(posedge i_clk) begin
        if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("[worker_health_tracker] ERROR");
            $finish;
        end
    end

    // Result receiver. Before each transaction it may hold ready low for a random
    // number of cycles; a new hold request from the stimulus makes one long stall.
    initial begin : receiver
        int stall;
        int holds_done;
        holds_done   = 0;
        res_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_requests != holds_done) begin
                stall      = HOLD_CYCLES;
                holds_done = hold_requests;
            end else begin
                stall = rx_idle ? $urandom_range(0, 8) : 0;
            end
            repeat (stall) begin
                @(negedge i_clk);
                res_if.ready = 1'b0;
            end
            @(negedge i_clk);
            res_if.ready = 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            board.check_result(res_if.data);
        end
    end

    // Offers one event and returns at the edge where it is taken. Valid is left
    // high so that a back-to-back event only changes the payload.
    task automatic drive_event(t_evt evt);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            evt_if.valid = 1'b0;
        end
        @(negedge i_clk);
        evt_if.valid = 1'b1;
        evt_if.data  = evt;
        do @(posedge i_clk); while (!evt_if.ready);
        board.note_event(evt);
    endtask

    task automatic send(logic [FUNC_W-1:0] func, logic [WIDX_W-1:0] worker,
                        logic [LAT_W-1:0] lat, t_health ih);
        t_evt evt;
        evt.func           = func;
        evt.worker         = worker;
        evt.lat_sample     = lat;
        evt.install_health = ih;
        drive_event(evt);
    endtask

    // Drops valid after the last event and waits until every owed result is in.
    // Each event causes a result, so once none is owed the pipeline is empty.
    task automatic wait_drained();
        @(negedge i_clk);
        evt_if.valid = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [THR_W-1:0] value);
        t_cfg c;
        c.index = idx;
        c.value = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.data  = c;
        do @(posedge i_clk); while (!cfg_if.ready);
        board.set_threshold(idx, value);
        cfg_writes++;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic write_thresholds(logic [THR_W-1:0] degrade, logic [THR_W-1:0] fail,
                                    logic [THR_W-1:0] recover);
        write_register(CFG_DEGRADE, degrade);
        write_register(CFG_FAIL, fail);
        write_register(CFG_RECOVER, recover);
    endtask

    function automatic logic [LAT_W-1:0] pick_latency();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return LAT_MAX;
            default: return LAT_W'($urandom_range(0, LAT_MAX));
        endcase
    endfunction

    // Random event biased toward the hot workers and toward well-formed traffic.
    // A small share names reserved function codes or random workers.
    function automatic t_evt random_event();
        t_evt evt;
        int   roll;
        roll = $urandom_range(0, 99);
        if (fail_heavy) begin
            if (roll < 8)       evt.func = FN_INSTALL;
            else if (roll < 38) evt.func = FN_SUCCESS;
            else if (roll < 85) evt.func = FN_FAILURE;
            else if (roll < 90) evt.func = FN_SET_DRAIN;
            else if (roll < 97) evt.func = FN_CLR_DRAIN;
            else evt.func = FUNC_W'($urandom_range(FN_RSVD_LO, FN_RSVD_HI));
        end else begin
            if (roll < 12)      evt.func = FN_INSTALL;
            else if (roll < 55) evt.func = FN_SUCCESS;
            else if (roll < 82) evt.func = FN_FAILURE;
            else if (roll < 89) evt.func = FN_SET_DRAIN;
            else if (roll < 97) evt.func = FN_CLR_DRAIN;
            else evt.func = FUNC_W'($urandom_range(FN_RSVD_LO, FN_RSVD_HI));
        end
        if ($urandom_range(0, 3) != 0)
            evt.worker = $urandom_range(0, 1) ? hot_a : hot_b;
        else
            evt.worker = WIDX_W'($urandom_range(0, WORKERS_DEF - 1));
        evt.lat_sample     = pick_latency();
        evt.install_health = $urandom_range(0, 1) ? HL_HEALTHY : t_health'($urandom_range(0, 3));
        return evt;
    endfunction

    initial begin : stimulus
        int k;
        int n;
        evt_if.valid  = 1'b0;
        evt_if.data   = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        i_rst_n       = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        hold_requests = 0;
        cfg_writes    = 0;
        hot_a         = '0;
        hot_b         = '0;
        fail_heavy    = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset thresholds (degrade 2, fail 5, recover 3).
        // Events to an entry that was never installed are refused.
        send(FN_SUCCESS, 4'd0, LAT_MAX, HL_HEALTHY);
        send(FN_SET_DRAIN, 4'd0, '0, HL_HEALTHY);
        send(FN_CLR_DRAIN, 4'd0, '0, HL_HEALTHY);
        // Latency at full scale stays at full scale, then decays toward zero.
        send(FN_INSTALL, 4'd0, LAT_MAX, HL_HEALTHY);
        send(FN_SUCCESS, 4'd0, LAT_MAX, HL_HEALTHY);
        send(FN_SUCCESS, 4'd0, '0, HL_HEALTHY);
        // Two failures degrade the worker, three successes bring it back.
        send(FN_FAILURE, 4'd0, '0, HL_HEALTHY);
        send(FN_FAILURE, 4'd0, '0, HL_HEALTHY);
        repeat (3) send(FN_SUCCESS, 4'd0, 20'h12345, HL_HEALTHY);
        // Five failures in a row fail it; after that everything but install is refused.
        repeat (5) send(FN_FAILURE, 4'd0, '0, HL_HEALTHY);
        send(FN_SUCCESS, 4'd0, LAT_MAX, HL_HEALTHY);
        send(FN_FAILURE, 4'd0, '0, HL_HEALTHY);
        send(FN_SET_DRAIN, 4'd0, '0, HL_HEALTHY);
        send(FN_CLR_DRAIN, 4'd0, '0, HL_HEALTHY);
        // An install may load draining or failed health directly.
        send(FN_INSTALL, 4'd15, '0, HL_DRAINING);
        send(FN_SUCCESS, 4'd15, LAT_MAX, HL_HEALTHY);
        send(FN_FAILURE, 4'd15, '0, HL_HEALTHY);
        send(FN_CLR_DRAIN, 4'd15, '0, HL_HEALTHY);
        send(FN_INSTALL, 4'd7, LAT_MAX, HL_FAILED);
        send(FN_SET_DRAIN, 4'd7, '0, HL_HEALTHY);
        send(FN_INSTALL, 4'd9, 20'h80000, HL_DEGRADED);
        // Reserved function codes are refused on a usable worker.
        send(FN_RSVD_LO, 4'd15, LAT_MAX, HL_HEALTHY);
        send(FN_RSVD_HI, 4'd15, LAT_MAX, HL_FAILED);
        wait_drained();

        // Long recovery threshold: a healthy worker's success count keeps climbing
        // past it, and a degraded one heals exactly when its count reaches it.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_thresholds(DEGRADE_RST, FAIL_RST, THR_W'(LONG_RECOVER));
        send(FN_INSTALL, 4'd2, 20'h00400, HL_HEALTHY);
        repeat (LONG_RECOVER + 3) send(FN_SUCCESS, 4'd2, pick_latency(), HL_HEALTHY);
        send(FN_INSTALL, 4'd3, '0, HL_DEGRADED);
        repeat (LONG_RECOVER) send(FN_SUCCESS, 4'd3, pick_latency(), HL_HEALTHY);
        send(FN_FAILURE, 4'd3, '0, HL_HEALTHY);
        wait_drained();

        // Random part: each chunk starts from a drained block, picks a threshold
        // setting (extremes, zero, crossed thresholds, random) and an idling mode.
        for (k = 0; k < CHUNKS; k++) begin
            case (k % 6)
                0: write_thresholds(DEGRADE_RST, FAIL_RST, RECOVER_RST);
                1: write_thresholds(16'd1, 16'd1, 16'd1);
                2: write_thresholds(THR_TOP, THR_TOP, THR_TOP);
                3: write_thresholds('0, '0, '0);
                4: write_thresholds(16'd6, 16'd3, 16'd1);
                default: begin
                    if (k == CHUNKS - 1)
                        write_thresholds(THR_W'($urandom_range(0, THR_TOP)),
                                         THR_W'($urandom_range(0, THR_TOP)),
                                         THR_W'($urandom_range(0, THR_TOP)));
                    else
                        write_thresholds(THR_W'($urandom_range(1, 4)),
                                         THR_W'($urandom_range(4, 9)),
                                         THR_W'($urandom_range(1, 5)));
                end
            endcase
            hot_a      = WIDX_W'($urandom_range(0, WORKERS_DEF - 1));
            hot_b      = WIDX_W'($urandom_range(0, WORKERS_DEF - 1));
            fail_heavy = ($urandom_range(0, 1) != 0);
            tx_idle    = (k % 3) != 1;
            rx_idle    = (k % 4) != 2;
            // One chunk runs the sender flat out against a long receiver stall,
            // so that the pipeline fills and the input is held off.
            if (k == 3) begin
                tx_idle = 1'b0;
                hold_requests++;
            end
            for (n = 0; n < CHUNK_EVENTS; n++) begin
                drive_event(random_event());
                // Midway through one chunk the sender waits for a fully drained block.
                if (k == 5 && n == CHUNK_EVENTS / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("Run covered %0d events (%0d applied, %0d refused) and %0d threshold writes,",
                 board.applied + board.refused, board.applied, board.refused, cfg_writes);
        $display("with %0d results checked and %0d mismatches.",
                 board.results_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[worker_health_tracker] OK");
        else
            $display("[worker_health_tracker] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ worker_health_tracker.f @@
+incdir+design
design/whtr_pkg.sv
design/whtr_chan_if.sv
design/whtr_ram.sv
design/whtr_update.sv
design/worker_health_tracker.sv
tb/worker_health_tracker_test.sv
